/* hdl/stgt_pkg.sv */
// Shared types, constants and serial-number helpers of the TSN gap tracker.
// No dependencies; the RAM, list engine, top level and testbench import it.
package stgt_pkg;

   localparam int MAX_BLOCKS = 32;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

   localparam logic [2:0] ACT_RECEIVE = 3'd0;
   localparam logic [2:0] ACT_REMOVE  = 3'd1;
   localparam logic [2:0] ACT_FORWARD = 3'd2;
   localparam logic [2:0] ACT_ADVANCE = 3'd3;
   localparam logic [2:0] ACT_RESET   = 3'd4;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] stop;
   } blk_type;

   typedef enum logic [1:0] {OP_UPDATE, OP_REMOVE, OP_FORWARD, OP_ADVANCE} op_type;

   typedef enum logic [1:0] {LST_COMB, LST_REV, LST_NONREV} lst_type;

   typedef struct packed {
      op_type           op;
      logic [31:0]      tsn;
      logic [31:0]      cum;
      logic [CNT_W-1:0] n;
   } eng_cmd_type;

   typedef struct packed {
      logic [31:0]      cum;
      logic [CNT_W-1:0] cnt;
      logic             above;
      logic             nc;
      logic             adv;
   } eng_res_type;

   typedef struct packed {
      logic [IDX_W-1:0] raddr;
      logic             we;
      logic [IDX_W-1:0] waddr;
      blk_type          wdata;
   } mem_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      blk_type          data;
   } wr_type;

   typedef enum logic [3:0] {
      E_IDLE, E_SCAN_RD, E_SCAN_EV, E_TAIL, E_NEXT,
      E_UP_RD, E_UP_WR, E_WR_A, E_WR_B, E_DN_RD, E_DN_WR, E_DONE
   } eng_state_type;

   typedef enum logic [3:0] {
      C_IDLE, C_RX_A, C_RX_B, C_RX_C, C_FWD_R, C_FWD_N,
      C_RM_R, C_RM_N, C_RM_C, C_FC, C_ADV, C_OUT
   } ctl_state_type;

   function automatic logic sn_ge(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return ~d[31];
   endfunction

   function automatic logic sn_gt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && ~d[31];
   endfunction

   function automatic logic sn_between(input logic [31:0] a, input logic [31:0] m,
                                       input logic [31:0] c);
      logic [31:0] dc;
      logic [31:0] dm;
      dc = c - a;
      dm = m - a;
      return dc >= dm;
   endfunction

endpackage

/* hdl/stgt_ifs.sv */
// Handshake channels of the TSN gap tracker: request and response items.
// Depends on nothing; field widths are fixed by the item format.
interface stgt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] tsn;
   logic        is_revokable;
   logic [31:0] cum_ack_value;

   modport source (output valid, action, tsn, is_revokable, cum_ack_value, input ready);
   modport sink   (input valid, action, tsn, is_revokable, cum_ack_value, output ready);
endinterface

interface stgt_rsp_if;
   logic        valid;
   logic        ready;
   logic        new_chunk;
   logic        not_covered;
   logic        advanced;
   logic [31:0] cum_ack_out;
   logic [5:0]  gap_count_out;

   modport source (output valid, new_chunk, not_covered, advanced, cum_ack_out,
                   gap_count_out, input ready);
   modport sink   (input valid, new_chunk, not_covered, advanced, cum_ack_out,
                   gap_count_out, output ready);
endinterface

/* hdl/stgt_ram.sv */
// One gap-block list store: one write port, one read port, registered read.
// Depends on stgt_pkg for the block type and depth.
module stgt_ram (
   input  logic                 clock,
   input  stgt_pkg::mem_req_type req,
   output stgt_pkg::blk_type     rdata
);
   import stgt_pkg::*;

   blk_type mem [MAX_BLOCKS];
   blk_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata_ff <= mem[req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/stgt_list_engine.sv */
// List engine: runs one update, remove, forward or advance on one block list,
// scanning entries through the RAM port and shifting them one per step.
// Depends on stgt_pkg.
module stgt_list_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  stgt_pkg::eng_cmd_type cmd,
   output stgt_pkg::eng_res_type res,
   output logic                  done,
   output stgt_pkg::mem_req_type mem_req,
   input  stgt_pkg::blk_type     rd_data
);
   import stgt_pkg::*;

   eng_state_type    state_ff, state_in;
   op_type           op_ff, op_in;
   logic [31:0]      t_ff, t_in;
   logic [31:0]      cum_ff, cum_in;
   logic [31:0]      lo_ff, lo_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] up_at_ff, up_at_in;
   logic [CNT_W-1:0] dn_d_ff, dn_d_in;
   logic [CNT_W-1:0] dn_lim_ff, dn_lim_in;
   logic             up_ff, up_in;
   logic             dn_ff, dn_in;
   wr_type           wa_ff, wa_in;
   wr_type           wb_ff, wb_in;
   blk_type          prev_ff, prev_in;
   logic             above_ff, above_in;
   logic             nc_ff, nc_in;
   logic             adv_ff, adv_in;

   logic [31:0]      scan_s, scan_e, upd_hi, upd_size, rem_size;
   logic [CNT_W-1:0] n_sat, jm1, jpd, im1, k_fin;
   logic             last, upd_hit, rem_hit, fwd_cond, scan_more, scan_tail;

   function automatic logic [IDX_W-1:0] i_in_next(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] w;
      w = v + CNT_ONE;
      return w[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] im1_n(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] w;
      w = v - CNT_ONE;
      return w[IDX_W-1:0];
   endfunction

   // scan decode
   always_comb begin
      scan_s    = rd_data.start;
      scan_e    = rd_data.stop;
      upd_hi    = scan_s - 32'd1;
      upd_size  = upd_hi - lo_ff + 32'd1;
      rem_size  = scan_e - scan_s + 32'd1;
      n_sat     = (n_ff == CNT_MAX) ? n_ff : n_ff + CNT_ONE;
      jm1       = j_ff - CNT_ONE;
      jpd       = j_ff + dn_d_ff;
      im1       = i_ff - CNT_ONE;
      last      = (i_ff + CNT_ONE) == n_ff;
      upd_hit   = sn_between(lo_ff, t_ff, upd_hi);
      rem_hit   = sn_between(scan_s, t_ff, scan_e);
      fwd_cond  = (op_ff == OP_FORWARD) ? sn_ge(cum_ff, scan_s)
                                        : ((cum_ff + 32'd1) == scan_s);
      k_fin     = fwd_cond ? i_ff + CNT_ONE : i_ff;
      scan_more = 1'b0;
      scan_tail = 1'b0;
      case (op_ff)
         OP_UPDATE: begin
            scan_more = !upd_hit && !last;
            scan_tail = !upd_hit && last;
         end
         OP_REMOVE: scan_more = !rem_hit && (i_ff != '0);
         default:   scan_more = fwd_cond && !last;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               if (cmd.op == OP_UPDATE && sn_ge(cmd.cum, cmd.tsn)) begin
                  state_in = E_NEXT;
               end else if (cmd.n == '0) begin
                  state_in = (cmd.op == OP_UPDATE) ? E_TAIL : E_NEXT;
               end else begin
                  state_in = E_SCAN_RD;
               end
            end
         end
         E_SCAN_RD: state_in = E_SCAN_EV;
         E_SCAN_EV: begin
            if (scan_more)      state_in = E_SCAN_RD;
            else if (scan_tail) state_in = E_TAIL;
            else                state_in = E_NEXT;
         end
         E_TAIL: state_in = E_NEXT;
         E_NEXT: begin
            if (up_ff) begin
               if (j_ff > up_at_ff) state_in = E_UP_RD;
            end else if (wa_ff.en) begin
               state_in = E_WR_A;
            end else if (wb_ff.en) begin
               state_in = E_WR_B;
            end else if (dn_ff) begin
               if (j_ff < dn_lim_ff) state_in = E_DN_RD;
            end else begin
               state_in = E_DONE;
            end
         end
         E_UP_RD: state_in = E_UP_WR;
         E_UP_WR: state_in = E_NEXT;
         E_WR_A:  state_in = E_NEXT;
         E_WR_B:  state_in = E_NEXT;
         E_DN_RD: state_in = E_DN_WR;
         E_DN_WR: state_in = E_NEXT;
         E_DONE:  state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      op_in = op_ff; t_in = t_ff; cum_in = cum_ff; lo_in = lo_ff; n_in = n_ff;
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; up_at_in = up_at_ff;
      dn_d_in = dn_d_ff; dn_lim_in = dn_lim_ff; up_in = up_ff; dn_in = dn_ff;
      wa_in = wa_ff; wb_in = wb_ff; prev_in = prev_ff;
      above_in = above_ff; nc_in = nc_ff; adv_in = adv_ff;
      mem_req = '0;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               op_in    = cmd.op;
               t_in     = cmd.tsn;
               cum_in   = cmd.cum;
               n_in     = cmd.n;
               cnt_in   = cmd.n;
               lo_in    = cmd.cum + 32'd1;
               i_in     = (cmd.op == OP_REMOVE) ? cmd.n - CNT_ONE : '0;
               up_in    = 1'b0;
               dn_in    = 1'b0;
               wa_in    = '0;
               wb_in    = '0;
               prev_in  = '0;
               above_in = (cmd.op == OP_UPDATE) && !sn_ge(cmd.cum, cmd.tsn);
               nc_in    = 1'b0;
               adv_in   = 1'b0;
            end
         end
         E_SCAN_RD: mem_req.raddr = i_ff[IDX_W-1:0];
         E_SCAN_EV: begin
            case (op_ff)
               OP_UPDATE: begin
                  if (upd_hit) begin
                     nc_in = 1'b1;
                     if (upd_size >= 32'd2) begin
                        if (t_ff == upd_hi) begin
                           wa_in = {1'b1, i_ff[IDX_W-1:0], t_ff, scan_e};
                        end else if (t_ff == lo_ff) begin
                           if (t_ff == cum_ff + 32'd1) begin
                              cum_in = cum_ff + 32'd1;
                           end else if (i_ff != '0) begin
                              wa_in = {1'b1, im1[IDX_W-1:0], prev_ff.start, t_ff};
                           end
                        end else begin
                           // open a slot and place a single-TSN block
                           up_in    = 1'b1;
                           up_at_in = i_ff;
                           j_in     = n_sat - CNT_ONE;
                           cnt_in   = n_sat;
                           wa_in    = {1'b1, i_ff[IDX_W-1:0], t_ff, t_ff};
                        end
                     end else begin
                        // gap closed: merge into predecessor or cum ack
                        if (lo_ff == cum_ff + 32'd1) begin
                           cum_in = scan_e;
                        end else if (i_ff != '0) begin
                           wa_in = {1'b1, im1[IDX_W-1:0], prev_ff.start, scan_e};
                        end
                        dn_in     = 1'b1;
                        dn_d_in   = CNT_ONE;
                        j_in      = i_ff;
                        dn_lim_in = n_ff - CNT_ONE;
                        cnt_in    = n_ff - CNT_ONE;
                     end
                  end else begin
                     lo_in   = scan_e + 32'd1;
                     prev_in = rd_data;
                     i_in    = i_ff + CNT_ONE;
                  end
               end
               OP_REMOVE: begin
                  if (rem_hit) begin
                     if (rem_size >= 32'd2 && rem_size <= 32'h7FFF_FFFF) begin
                        if (scan_e == t_ff) begin
                           wa_in = {1'b1, i_ff[IDX_W-1:0], scan_s, scan_e - 32'd1};
                        end else if (scan_s == t_ff) begin
                           wa_in = {1'b1, i_ff[IDX_W-1:0], scan_s + 32'd1, scan_e};
                        end else begin
                           // split the block
                           up_in    = 1'b1;
                           up_at_in = i_ff;
                           j_in     = n_sat - CNT_ONE;
                           cnt_in   = n_sat;
                           wa_in    = {1'b1, i_ff[IDX_W-1:0], scan_s, t_ff - 32'd1};
                           if ((i_ff + CNT_ONE) < n_sat) begin
                              wb_in = {1'b1, i_in_next(i_ff), t_ff + 32'd1, scan_e};
                           end
                        end
                     end else begin
                        dn_in     = 1'b1;
                        dn_d_in   = CNT_ONE;
                        j_in      = i_ff;
                        dn_lim_in = n_ff - CNT_ONE;
                        cnt_in    = n_ff - CNT_ONE;
                     end
                  end else if (i_ff != '0) begin
                     i_in = i_ff - CNT_ONE;
                  end
               end
               default: begin
                  if (fwd_cond && op_ff == OP_ADVANCE) begin
                     cum_in = scan_e;
                     adv_in = 1'b1;
                  end
                  if (scan_more) begin
                     i_in = i_ff + CNT_ONE;
                  end else if (k_fin != '0) begin
                     // drop the leading k_fin blocks
                     dn_in     = 1'b1;
                     dn_d_in   = k_fin;
                     j_in      = '0;
                     dn_lim_in = n_ff - k_fin;
                     cnt_in    = n_ff - k_fin;
                  end
               end
            endcase
         end
         E_TAIL: begin
            if (t_ff == lo_ff) begin
               nc_in = 1'b1;
               if (t_ff == cum_ff + 32'd1) begin
                  cum_in = t_ff;
               end else if (n_ff != '0) begin
                  wa_in = {1'b1, im1_n(n_ff), prev_ff.start, prev_ff.stop + 32'd1};
               end
            end else if (n_ff == '0 || sn_gt(t_ff, prev_ff.stop + 32'd1)) begin
               if (n_ff < CNT_MAX) begin
                  wa_in  = {1'b1, n_ff[IDX_W-1:0], t_ff, t_ff};
                  cnt_in = n_ff + CNT_ONE;
                  nc_in  = 1'b1;
               end
            end
         end
         E_NEXT: begin
            if (up_ff) begin
               if (!(j_ff > up_at_ff)) up_in = 1'b0;
            end else if (!wa_ff.en && !wb_ff.en && dn_ff) begin
               if (!(j_ff < dn_lim_ff)) dn_in = 1'b0;
            end
         end
         E_UP_RD: mem_req.raddr = jm1[IDX_W-1:0];
         E_UP_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = j_ff[IDX_W-1:0];
            mem_req.wdata = rd_data;
            j_in          = jm1;
         end
         E_WR_A: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wa_ff.addr;
            mem_req.wdata = wa_ff.data;
            wa_in.en      = 1'b0;
         end
         E_WR_B: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wb_ff.addr;
            mem_req.wdata = wb_ff.data;
            wb_in.en      = 1'b0;
         end
         E_DN_RD: mem_req.raddr = jpd[IDX_W-1:0];
         E_DN_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = j_ff[IDX_W-1:0];
            mem_req.wdata = rd_data;
            j_in          = j_ff + CNT_ONE;
         end
         E_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; t_ff <= t_in; cum_ff <= cum_in; lo_ff <= lo_in; n_ff <= n_in;
      cnt_ff <= cnt_in; i_ff <= i_in; j_ff <= j_in; up_at_ff <= up_at_in;
      dn_d_ff <= dn_d_in; dn_lim_ff <= dn_lim_in; up_ff <= up_in; dn_ff <= dn_in;
      wa_ff <= wa_in; wb_ff <= wb_in; prev_ff <= prev_in;
      above_ff <= above_in; nc_ff <= nc_in; adv_ff <= adv_in;
   end

   assign done = (state_ff == E_DONE);
   assign res  = '{cum: cum_ff, cnt: cnt_ff, above: above_ff, nc: nc_ff, adv: adv_ff};

endmodule

/* hdl/sctp_tsn_gap_tracker.sv */
// Top level of the SCTP receive TSN gap tracker: item sequencer, cumulative
// ack, list counts, three list RAMs and the shared list engine.
// Depends on stgt_pkg, stgt_ifs (channels), stgt_ram and stgt_list_engine.
//
//   channel   | dir | handshake     | carries
//   ----------+-----+---------------+---------------------------------------
//   req_chan  | in  | valid / ready | action, tsn, is_revokable, cum_ack_value
//   rsp_chan  | out | valid / ready | new_chunk, not_covered, advanced,
//             |     |               | cum_ack_out, gap_count_out
//
// One item at a time. Each item runs zero to five list passes on the shared
// engine (none for reset or an unknown action); a pass scans, shifts and
// writes the entries of one list, which holds up to 32 entries.
// Reset is synchronous: cum ack and all counts clear; list RAMs are not swept.
// The response register holds a finished item while the next one is worked on;
// a stalled response only blocks the item after that one.
module sctp_tsn_gap_tracker (
   input logic       clock,
   input logic       reset,
   stgt_req_if.sink   req_chan,
   stgt_rsp_if.source rsp_chan
);
   import stgt_pkg::*;

   ctl_state_type    cst_ff, cst_in;
   logic             launched_ff, launched_in;
   logic [31:0]      cum_ack_ff, cum_ack_in;
   logic [CNT_W-1:0] cnt_comb_ff, cnt_comb_in;
   logic [CNT_W-1:0] cnt_rev_ff, cnt_rev_in;
   logic [CNT_W-1:0] cnt_nonrev_ff, cnt_nonrev_in;
   logic [31:0]      tsn_ff, tsn_in;
   logic             revok_ff, revok_in;
   logic             nc_ff, nc_in;
   logic             above_ff, above_in;
   logic             adv_ff, adv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_nc_ff, rsp_nc_in;
   logic             rsp_above_ff, rsp_above_in;
   logic             rsp_adv_ff, rsp_adv_in;
   logic [31:0]      rsp_cum_ff, rsp_cum_in;
   logic [5:0]       rsp_gap_ff, rsp_gap_in;

   lst_type          sel;
   logic             step;
   logic             eng_start;
   logic             eng_done;
   eng_cmd_type      eng_cmd;
   eng_res_type      eng_res;
   mem_req_type      eng_mem;
   mem_req_type      mem_comb, mem_rev, mem_nonrev;
   blk_type          rd_comb, rd_rev, rd_nonrev, rd_sel;
   logic             accept;
   logic             out_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // engine command for the current pass
   always_comb begin
      sel         = LST_COMB;
      step        = 1'b1;
      eng_cmd.op  = OP_UPDATE;
      unique case (cst_ff)
         C_RX_A:  begin sel = revok_ff ? LST_REV : LST_NONREV; eng_cmd.op = OP_UPDATE; end
         C_RX_B:  begin sel = LST_REV;    eng_cmd.op = OP_REMOVE;  end
         C_RX_C:  begin sel = LST_COMB;   eng_cmd.op = OP_UPDATE;  end
         C_FWD_R: begin sel = LST_REV;    eng_cmd.op = OP_FORWARD; end
         C_FWD_N: begin sel = LST_NONREV; eng_cmd.op = OP_FORWARD; end
         C_RM_R:  begin sel = LST_REV;    eng_cmd.op = OP_REMOVE;  end
         C_RM_N:  begin sel = LST_NONREV; eng_cmd.op = OP_REMOVE;  end
         C_RM_C:  begin sel = LST_COMB;   eng_cmd.op = OP_REMOVE;  end
         C_FC:    begin sel = LST_COMB;   eng_cmd.op = OP_FORWARD; end
         C_ADV:   begin sel = LST_COMB;   eng_cmd.op = OP_ADVANCE; end
         default: step = 1'b0;
      endcase
      eng_cmd.tsn = tsn_ff;
      eng_cmd.cum = cum_ack_ff;
      case (sel)
         LST_REV:    eng_cmd.n = cnt_rev_ff;
         LST_NONREV: eng_cmd.n = cnt_nonrev_ff;
         default:    eng_cmd.n = cnt_comb_ff;
      endcase
      eng_start = step && !launched_ff;
   end

   // next state
   always_comb begin
      cst_in = cst_ff;
      unique case (cst_ff)
         C_IDLE: begin
            if (accept) begin
               unique case (req_chan.action)
                  ACT_RECEIVE: cst_in = C_RX_A;
                  ACT_REMOVE:  cst_in = C_RM_R;
                  ACT_FORWARD: cst_in = C_FC;
                  ACT_ADVANCE: cst_in = C_ADV;
                  default:     cst_in = C_OUT;
               endcase
            end
         end
         C_RX_A:  if (eng_done) cst_in = (!revok_ff && eng_res.above) ? C_RX_B : C_RX_C;
         C_RX_B:  if (eng_done) cst_in = C_RX_C;
         C_RX_C:  if (eng_done) cst_in = (eng_res.cum != cum_ack_ff) ? C_FWD_R : C_OUT;
         C_FC:    if (eng_done) cst_in = C_FWD_R;
         C_ADV:   if (eng_done) cst_in = eng_res.adv ? C_FWD_R : C_OUT;
         C_FWD_R: if (eng_done) cst_in = C_FWD_N;
         C_FWD_N: if (eng_done) cst_in = C_OUT;
         C_RM_R:  if (eng_done) cst_in = C_RM_N;
         C_RM_N:  if (eng_done) cst_in = C_RM_C;
         C_RM_C:  if (eng_done) cst_in = C_OUT;
         C_OUT:   if (out_free) cst_in = C_IDLE;
         default: cst_in = C_IDLE;
      endcase
   end

   // item state and response register
   always_comb begin
      launched_in   = launched_ff;
      cum_ack_in    = cum_ack_ff;
      cnt_comb_in   = cnt_comb_ff;
      cnt_rev_in    = cnt_rev_ff;
      cnt_nonrev_in = cnt_nonrev_ff;
      tsn_in        = tsn_ff;
      revok_in      = revok_ff;
      nc_in         = nc_ff;
      above_in      = above_ff;
      adv_in        = adv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_nc_in     = rsp_nc_ff;
      rsp_above_in  = rsp_above_ff;
      rsp_adv_in    = rsp_adv_ff;
      rsp_cum_in    = rsp_cum_ff;
      rsp_gap_in    = rsp_gap_ff;

      if (eng_start) launched_in = 1'b1;

      if (accept) begin
         tsn_in   = req_chan.tsn;
         revok_in = req_chan.is_revokable;
         nc_in    = 1'b0;
         above_in = 1'b0;
         adv_in   = 1'b0;
         if (req_chan.action == ACT_FORWARD) begin
            cum_ack_in = req_chan.cum_ack_value;
         end
         if (req_chan.action == ACT_RESET) begin
            cum_ack_in    = req_chan.cum_ack_value;
            cnt_comb_in   = '0;
            cnt_rev_in    = '0;
            cnt_nonrev_in = '0;
         end
      end

      if (eng_done) begin
         launched_in = 1'b0;
         nc_in       = nc_ff | eng_res.nc;
         case (sel)
            LST_REV:    cnt_rev_in    = eng_res.cnt;
            LST_NONREV: cnt_nonrev_in = eng_res.cnt;
            default:    cnt_comb_in   = eng_res.cnt;
         endcase
         if (cst_ff == C_RX_C) begin
            above_in   = eng_res.above;
            cum_ack_in = eng_res.cum;
         end
         if (cst_ff == C_ADV) begin
            adv_in     = eng_res.adv;
            cum_ack_in = eng_res.cum;
         end
      end

      if (cst_ff == C_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_nc_in    = nc_ff;
         rsp_above_in = above_ff;
         rsp_adv_in   = adv_ff;
         rsp_cum_in   = cum_ack_ff;
         rsp_gap_in   = 6'(cnt_comb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cst_ff        <= C_IDLE;
         launched_ff   <= 1'b0;
         cum_ack_ff    <= '0;
         cnt_comb_ff   <= '0;
         cnt_rev_ff    <= '0;
         cnt_nonrev_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cst_ff        <= cst_in;
         launched_ff   <= launched_in;
         cum_ack_ff    <= cum_ack_in;
         cnt_comb_ff   <= cnt_comb_in;
         cnt_rev_ff    <= cnt_rev_in;
         cnt_nonrev_ff <= cnt_nonrev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tsn_ff       <= tsn_in;
      revok_ff     <= revok_in;
      nc_ff        <= nc_in;
      above_ff     <= above_in;
      adv_ff       <= adv_in;
      rsp_nc_ff    <= rsp_nc_in;
      rsp_above_ff <= rsp_above_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_cum_ff   <= rsp_cum_in;
      rsp_gap_ff   <= rsp_gap_in;
   end

   // steer the engine's memory port to the selected list
   always_comb begin
      mem_comb      = eng_mem;
      mem_rev       = eng_mem;
      mem_nonrev    = eng_mem;
      mem_comb.we   = eng_mem.we && (sel == LST_COMB);
      mem_rev.we    = eng_mem.we && (sel == LST_REV);
      mem_nonrev.we = eng_mem.we && (sel == LST_NONREV);
      case (sel)
         LST_REV:    rd_sel = rd_rev;
         LST_NONREV: rd_sel = rd_nonrev;
         default:    rd_sel = rd_comb;
      endcase
   end

   stgt_ram u_ram_comb   (.clock(clock), .req(mem_comb),   .rdata(rd_comb));
   stgt_ram u_ram_rev    (.clock(clock), .req(mem_rev),    .rdata(rd_rev));
   stgt_ram u_ram_nonrev (.clock(clock), .req(mem_nonrev), .rdata(rd_nonrev));

   stgt_list_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (eng_start),
      .cmd     (eng_cmd),
      .res     (eng_res),
      .done    (eng_done),
      .mem_req (eng_mem),
      .rd_data (rd_sel)
   );

   assign req_chan.ready         = (cst_ff == C_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.new_chunk     = rsp_nc_ff;
   assign rsp_chan.not_covered   = rsp_above_ff;
   assign rsp_chan.advanced      = rsp_adv_ff;
   assign rsp_chan.cum_ack_out   = rsp_cum_ff;
   assign rsp_chan.gap_count_out = rsp_gap_ff;

endmodule

/* tb/tb_sctp_tsn_gap_tracker.sv */
// Self-checking testbench of the SCTP receive TSN gap tracker.
// Depends on stgt_pkg, stgt_ifs and the block sctp_tsn_gap_tracker.
module tb_sctp_tsn_gap_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import stgt_pkg::*;

   localparam int NUM_RANDOM = 500;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] tsn;
      logic        revok;
      logic [31:0] value;
   } item_type;

   typedef struct {
      logic        nc;
      logic        above;
      logic        adv;
      logic [31:0] cum;
      logic [5:0]  cnt;
   } ack_type;

   // one gap-ack list of the predictor
   typedef struct {
      logic [31:0] start [MAX_BLOCKS];
      logic [31:0] stop  [MAX_BLOCKS];
      int          n;
   } gap_list_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stgt_req_if req_chan ();
   stgt_rsp_if rsp_chan ();

   sctp_tsn_gap_tracker u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0]  pred_cum;
   gap_list_type comb_gaps, rev_gaps, nonrev_gaps;
   ack_type      acks_due [$];
   int           errors = 0;
   bit           rsp_calm = 1'b0;

   // serial-number ordering
   function automatic bit after_eq(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return !d[31];
   endfunction

   function automatic bit after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 0 && !d[31];
   endfunction

   function automatic bit lies_between(logic [31:0] a, logic [31:0] m, logic [31:0] c);
      logic [31:0] dc, dm;
      dc = c - a;
      dm = m - a;
      return dc >= dm;
   endfunction

   function automatic void drop_gap(ref gap_list_type l, input int i);
      if (i >= l.n) return;
      for (int j = i; j + 1 < l.n; j++) begin
         l.start[j] = l.start[j+1];
         l.stop[j]  = l.stop[j+1];
      end
      l.n--;
   endfunction

   // open slot i; the tail block falls off a full list
   function automatic void open_gap(ref gap_list_type l, input int i);
      int n;
      n = (l.n + 1 > MAX_BLOCKS) ? MAX_BLOCKS : l.n + 1;
      for (int j = n - 1; j > i; j--) begin
         l.start[j] = l.start[j-1];
         l.stop[j]  = l.stop[j-1];
      end
      l.n = n;
   endfunction

   function automatic void forward_gaps(ref gap_list_type l, input logic [31:0] c);
      int k;
      k = 0;
      while (k < l.n && after_eq(c, l.start[k])) k++;
      repeat (k) drop_gap(l, 0);
   endfunction

   function automatic void renege_gap(ref gap_list_type l, input logic [31:0] t);
      logic [31:0] size;
      for (int i = l.n - 1; i >= 0; i--) begin
         if (!lies_between(l.start[i], t, l.stop[i])) continue;
         size = l.stop[i] - l.start[i] + 1;
         if (size >= 2 && size <= 32'h7FFF_FFFF) begin
            if (l.stop[i] == t) l.stop[i]--;
            else if (l.start[i] == t) l.start[i]++;
            else begin
               open_gap(l, i);
               l.stop[i] = t - 1;
               if (i + 1 < l.n) l.start[i+1] = t + 1;
            end
         end else begin
            drop_gap(l, i);
         end
         return;
      end
   endfunction

   // record t in a list; returns 1 when t lay above cum
   function automatic bit record_tsn(ref gap_list_type l, input logic [31:0] t,
                                     ref logic [31:0] cum, ref logic nc);
      logic [31:0] lo, hi;
      int n;
      if (after_eq(cum, t)) return 1'b0;
      lo = cum + 1;
      n  = l.n;
      for (int i = 0; i < n; i++) begin
         hi = l.start[i] - 1;
         if (lies_between(lo, t, hi)) begin
            if (hi - lo + 1 > 1) begin
               if (t == hi) l.start[i] = t;
               else if (t == lo) begin
                  if (t == cum + 1) cum++;
                  else if (i > 0) l.stop[i-1] = t;
               end else begin
                  open_gap(l, i);
                  l.start[i] = t;
                  l.stop[i]  = t;
               end
            end else begin
               if (lo == cum + 1) cum = l.stop[i];
               else if (i > 0) l.stop[i-1] = l.stop[i];
               drop_gap(l, i);
            end
            nc = 1'b1;
            return 1'b1;
         end
         lo = l.stop[i] + 1;
      end
      if (t == lo) begin
         if (t == cum + 1) cum = t;
         else if (n > 0) l.stop[n-1]++;
         nc = 1'b1;
         return 1'b1;
      end
      if (n == 0 || after(t, l.stop[n-1] + 1)) begin
         if (n < MAX_BLOCKS) begin
            l.start[n] = t;
            l.stop[n]  = t;
            l.n = n + 1;
            nc = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic ack_type track_tsn(item_type it);
      ack_type     r;
      logic [31:0] copy, prev;
      r = '{default: '0};
      case (it.action)
         ACT_RECEIVE: begin
            copy = pred_cum;
            if (it.revok) void'(record_tsn(rev_gaps, it.tsn, copy, r.nc));
            else if (record_tsn(nonrev_gaps, it.tsn, copy, r.nc))
               renege_gap(rev_gaps, it.tsn);
            prev = pred_cum;
            r.above = record_tsn(comb_gaps, it.tsn, pred_cum, r.nc);
            if (prev != pred_cum) begin
               forward_gaps(rev_gaps, pred_cum);
               forward_gaps(nonrev_gaps, pred_cum);
            end
         end
         ACT_REMOVE: begin
            renege_gap(rev_gaps, it.tsn);
            renege_gap(nonrev_gaps, it.tsn);
            renege_gap(comb_gaps, it.tsn);
         end
         ACT_FORWARD: begin
            pred_cum = it.value;
            forward_gaps(comb_gaps, pred_cum);
            forward_gaps(rev_gaps, pred_cum);
            forward_gaps(nonrev_gaps, pred_cum);
         end
         ACT_ADVANCE: begin
            while (comb_gaps.n > 0 && pred_cum + 1 == comb_gaps.start[0]) begin
               pred_cum = comb_gaps.stop[0];
               drop_gap(comb_gaps, 0);
               r.adv = 1'b1;
            end
            if (r.adv) begin
               forward_gaps(rev_gaps, pred_cum);
               forward_gaps(nonrev_gaps, pred_cum);
            end
         end
         ACT_RESET: begin
            pred_cum = it.value;
            comb_gaps.n = 0;
            rev_gaps.n = 0;
            nonrev_gaps.n = 0;
         end
         default: ;
      endcase
      r.cum = pred_cum;
      r.cnt = 6'(comb_gaps.n);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, compare each item with the oldest due
   // ---------------------------------------------------------------------
   initial rsp_chan.ready = 1'b0;

   always @(negedge clock)
      if (!reset) rsp_chan.ready <= rsp_calm || ($urandom_range(99) >= 30);

   always @(posedge clock) begin
      ack_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (acks_due.size() == 0) begin
            $display("[%0t] mismatch: response item with nothing due", $realtime);
            errors++;
         end else begin
            w = acks_due.pop_front();
            if (rsp_chan.new_chunk !== w.nc) report_mismatch("new_chunk", rsp_chan.new_chunk, w.nc);
            if (rsp_chan.not_covered !== w.above)
               report_mismatch("not_covered", rsp_chan.not_covered, w.above);
            if (rsp_chan.advanced !== w.adv) report_mismatch("advanced", rsp_chan.advanced, w.adv);
            if (rsp_chan.cum_ack_out !== w.cum)
               report_mismatch("cum_ack_out", rsp_chan.cum_ack_out, w.cum);
            if (rsp_chan.gap_count_out !== w.cnt)
               report_mismatch("gap_count_out", rsp_chan.gap_count_out, w.cnt);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   bit req_calm = 1'b0;

   // hold the item until accepted; idle at random before it
   task automatic send_item(item_type it, bit typed, ack_type typed_ack);
      ack_type p;
      while (!req_calm && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.action        <= it.action;
      req_chan.tsn           <= it.tsn;
      req_chan.is_revokable  <= it.revok;
      req_chan.cum_ack_value <= it.value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      p = track_tsn(it);
      if (typed && p != typed_ack) begin
         // a hand-typed row disagreeing with the predictor is a fault too
         $display("[%0t] mismatch: typed row disagrees with prediction", $realtime);
         errors++;
      end
      acks_due.push_back(typed ? typed_ack : p);
      // the block drops ready once it takes an item, so valid may stay up until
      // the next item or an idle cycle takes it down
      @(negedge clock);
   endtask

   task automatic drain_acks();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (acks_due.size() != 0);
   endtask

   // random item aimed near the cum ack so blocks build, merge and split
   function automatic item_type pick_item(int mode);
      item_type it;
      int r;
      it.revok = 1'($urandom_range(1));
      it.value = $urandom;
      it.tsn   = $urandom;
      r = $urandom_range(99);
      if (mode == 0) begin
         // well-formed receive traffic
         it.action = r < 70 ? ACT_RECEIVE : r < 82 ? ACT_REMOVE : r < 94 ? ACT_ADVANCE : ACT_FORWARD;
         it.tsn = pred_cum + 32'($urandom_range(48)) - 32'($urandom_range(3));
         if (it.action == ACT_FORWARD) it.value = pred_cum + 32'($urandom_range(20));
      end else begin
         // noise: any action code, wide TSNs, resets
         it.action = 3'($urandom_range(7));
         if (r < 50) it.tsn = pred_cum + $urandom_range(200);
         if (r < 30) it.value = pred_cum + $urandom_range(30);
      end
      return it;
   endfunction

   typedef struct {
      item_type it;
      bit       typed;
      ack_type  ack;
   } row_type;

   // directed rows; typed acks only where plain from the rules
   row_type steps [] = '{
      '{'{ACT_ADVANCE, 32'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 6'd0}},
      '{'{ACT_RECEIVE, 32'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 6'd0}},
      '{'{ACT_RECEIVE, 32'd1, 1'b0, 32'd0}, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd1, 6'd0}},
      '{'{ACT_RECEIVE, 32'd5, 1'b1, 32'd0}, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd1, 6'd1}},
      '{'{ACT_RECEIVE, 32'd7, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RECEIVE, 32'd6, 1'b1, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RECEIVE, 32'd3, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_REMOVE,  32'd6, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_REMOVE,  32'd7, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RECEIVE, 32'd2, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_ADVANCE, 32'd0, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{3'd5, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b0, '{default: '0}},
      '{'{3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b0, '{default: '0}},
      '{'{ACT_FORWARD, 32'd0, 1'b0, 32'd6}, 1'b0, '{default: '0}},
      '{'{ACT_RESET,   32'd0, 1'b0, 32'hFFFF_FFFE}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 32'hFFFF_FFFE, 6'd0}},
      '{'{ACT_RECEIVE, 32'h0000_0001, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RECEIVE, 32'hFFFF_FFFF, 1'b1, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_ADVANCE, 32'd0, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RECEIVE, 32'h8000_0000, 1'b0, 32'd0}, 1'b0, '{default: '0}},
      '{'{ACT_RESET,   32'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 6'd0}}
   };

   initial begin
      item_type it;
      comb_gaps.n = 0;
      rev_gaps.n = 0;
      nonrev_gaps.n = 0;
      pred_cum = '0;
      req_chan.valid         = 1'b0;
      req_chan.action        = ACT_RESET;
      req_chan.tsn           = '0;
      req_chan.is_revokable  = 1'b0;
      req_chan.cum_ack_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (steps[i]) send_item(steps[i].it, steps[i].typed, steps[i].ack);

      // fill the combined list past full: every other TSN leaves a gap
      for (int k = 0; k < 36; k++)
         send_item('{ACT_RECEIVE, 32'(2 * k + 2), k[0], '0}, 1'b0, '{default: '0});
      // remove a single-TSN block near the head of a full list
      send_item('{ACT_REMOVE, 32'd4, 1'b0, '0}, 1'b0, '{default: '0});
      send_item('{ACT_RECEIVE, 32'd3, 1'b0, '0}, 1'b0, '{default: '0});
      // forward past a gap block: reset, record one block, move the cum ack beyond it
      send_item('{ACT_RESET, '0, 1'b0, 32'd0}, 1'b0, '{default: '0});
      send_item('{ACT_RECEIVE, 32'd2, 1'b0, '0}, 1'b0, '{default: '0});
      send_item('{ACT_FORWARD, '0, 1'b0, 32'h7000_0000}, 1'b0, '{default: '0});

      // pause until everything has come back
      drain_acks();

      for (int k = 0; k < NUM_RANDOM; k++) begin
         req_calm = (k >= 150 && k < 230);
         rsp_calm = req_calm;
         if (k % 120 == 119) drain_acks();
         it = pick_item($urandom_range(99) < 85 ? 0 : 1);
         send_item(it, 1'b0, '{default: '0});
      end
      rsp_calm = 1'b0;

      drain_acks();
      repeat (400) @(posedge clock);
      if (errors == 0 && acks_due.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #100ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* filelist.f */
hdl/stgt_pkg.sv
hdl/stgt_ifs.sv
hdl/stgt_ram.sv
hdl/stgt_list_engine.sv
hdl/sctp_tsn_gap_tracker.sv
tb/tb_sctp_tsn_gap_tracker.sv
